[rtl/core/asa_pkg.sv]
// package for the aligned stack allocator: sizes, codes and payload types
// no dependencies; every other file of the block but asa_ram uses it
`timescale 1ns / 1ps

package asa_pkg;

  // built store depth and alignment limit
  localparam int unsigned ARENA_BYTES    = 4096;
  localparam int unsigned MAX_ALIGN_LOG2 = 7;

  // fixed field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned TOP_W   = 13;
  localparam int unsigned ALIGN_W = 3;
  localparam int unsigned HDR_W   = 8;
  localparam int unsigned OFF_W   = $clog2(ARENA_BYTES);

  localparam logic [ALIGN_W-1:0] ALIGN_MAX   = ALIGN_W'(MAX_ALIGN_LOG2);
  localparam logic [TOP_W-1:0]   ARENA_LIMIT = TOP_W'(ARENA_BYTES);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARENA_BASE = 1'b0,
    CFG_ARENA_SIZE = 1'b1
  } asa_cfg_idx_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } asa_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } asa_state_e;

  typedef struct packed {
    asa_op_e              opcode;
    logic [TOP_W-1:0]     request_size;
    logic [ALIGN_W-1:0]   align_log2;
    logic [ADDR_W-1:0]    free_address;
  } asa_req_t;

  typedef struct packed {
    logic                 ok;
    logic [ADDR_W-1:0]    block_address;
    logic [TOP_W-1:0]     top_after;
  } asa_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic finish;
  } asa_cmd_t;

endpackage

[rtl/core/asa_ram.sv]
// generic simple dual-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module asa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/asa_ctrl.sv]
// request sequencer for the aligned stack allocator
// depends on asa_pkg
`timescale 1ns / 1ps

module asa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              rsp_valid_o,
  output asa_pkg::asa_cmd_t cmd_o
);

  asa_pkg::asa_state_e state_q, state_d;
  logic                done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asa_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    done_d      = 1'b0;
    busy        = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      asa_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = asa_pkg::ST_EXEC;
        end
      end
      asa_pkg::ST_EXEC: begin
        busy         = 1'b1;
        cmd_o.finish = 1'b1;
        done_d       = 1'b1;
        state_d      = asa_pkg::ST_IDLE;
      end
      default: begin
        state_d = asa_pkg::ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_o = done_q;

endmodule

[rtl/core/asa_datapath.sv]
// datapath: config registers, top offset, alignment math, header ram
// depends on asa_pkg and asa_ram
`timescale 1ns / 1ps

module asa_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  asa_pkg::asa_cmd_t                     cmd_i,
  input  asa_pkg::asa_req_t                     req_i,
  input  logic                                  cfg_we_i,
  input  logic [asa_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [asa_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output asa_pkg::asa_rsp_t                     rsp_o
);

  localparam int unsigned AW = asa_pkg::ADDR_W;
  localparam int unsigned TW = asa_pkg::TOP_W;
  localparam int unsigned HW = asa_pkg::HDR_W;
  localparam int unsigned OW = asa_pkg::OFF_W;

  // config and architectural state
  logic [AW-1:0] base_q;
  logic [TW-1:0] size_q;
  logic [TW-1:0] top_q, top_d;

  // first-stage registers
  asa_pkg::asa_op_e op_q;
  logic [TW-1:0]    rsize_q;
  logic [AW-1:0]    aligned_q;
  logic [HW-1:0]    dist_q;
  logic [TW-1:0]    foff_q;
  logic             fbad_q;

  asa_pkg::asa_rsp_t rsp_q, rsp_d;

  // first stage
  logic [asa_pkg::ALIGN_W-1:0] lg_sat;
  logic [HW-1:0]               mask;
  logic [AW-1:0]               sum;
  logic [AW-1:0]               aligned;
  logic [HW-1:0]               bt_low;
  logic [HW-1:0]               hdr_dist;
  logic [AW-1:0]               foff;
  logic [AW-1:0]               foff_m1;
  logic [TW-1:0]               lim;
  logic                        fbad;
  logic                        rd_en;

  // second stage
  logic [TW-1:0] blk_off;
  logic [TW:0]   end_off;
  logic          fit;
  logic [OW-1:0] hdr_waddr;
  logic          hdr_we;
  logic [HW-1:0] hdr_rdata;
  logic [TW-1:0] hdr_ext;

  always_comb begin
    lim = (size_q > asa_pkg::ARENA_LIMIT) ? asa_pkg::ARENA_LIMIT : size_q;

    lg_sat = (req_i.align_log2 > asa_pkg::ALIGN_MAX) ? asa_pkg::ALIGN_MAX
                                                      : req_i.align_log2;
    mask   = (HW'(1) << lg_sat) - HW'(1);
    // base + top + 1 rounded up to the alignment
    sum     = base_q + AW'(top_q) + AW'(mask) + AW'(1);
    aligned = sum & ~AW'(mask);
    // distance from old top: one header byte plus padding
    bt_low   = base_q[HW-1:0] + top_q[HW-1:0];
    hdr_dist = HW'(1) + (~bt_low & mask);

    foff    = req_i.free_address - base_q;
    foff_m1 = req_i.free_address + ~base_q;
    fbad    = (foff == '0) || (foff > AW'(lim));
    rd_en   = cmd_i.capture && (req_i.opcode == asa_pkg::OP_FREE);
  end

  always_comb begin
    blk_off   = top_q + TW'(dist_q);
    end_off   = (TW+1)'(blk_off) + (TW+1)'(rsize_q);
    fit       = end_off <= (TW+1)'(lim);
    hdr_waddr = OW'(blk_off - TW'(1));
    hdr_ext   = TW'(hdr_rdata);
    hdr_we    = 1'b0;
    top_d     = top_q;
    rsp_d     = rsp_q;
    if (cmd_i.finish) begin
      rsp_d.ok            = 1'b0;
      rsp_d.block_address = '0;
      unique case (op_q)
        asa_pkg::OP_ALLOC: begin
          if (fit) begin
            hdr_we              = 1'b1;
            top_d               = end_off[TW-1:0];
            rsp_d.ok            = 1'b1;
            rsp_d.block_address = aligned_q;
          end
        end
        asa_pkg::OP_FREE: begin
          if (!fbad_q) begin
            top_d    = (hdr_ext > foff_q) ? '0 : foff_q - hdr_ext;
            rsp_d.ok = 1'b1;
          end
        end
        default: begin
        end
      endcase
      rsp_d.top_after = top_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      size_q <= asa_pkg::ARENA_LIMIT;
      top_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (asa_pkg::asa_cfg_idx_e'(cfg_index_i))
          asa_pkg::CFG_ARENA_BASE: base_q <= cfg_data_i[AW-1:0];
          asa_pkg::CFG_ARENA_SIZE: size_q <= cfg_data_i[TW-1:0];
          default: begin
          end
        endcase
      end
      top_q <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= req_i.opcode;
      rsize_q   <= req_i.request_size;
      aligned_q <= aligned;
      dist_q    <= hdr_dist;
      foff_q    <= foff[TW-1:0];
      fbad_q    <= fbad;
    end
    rsp_q <= rsp_d;
  end

  asa_ram #(
    .WIDTH(HW),
    .DEPTH(asa_pkg::ARENA_BYTES)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (hdr_we),
    .waddr_i(hdr_waddr),
    .wdata_i(dist_q),
    .re_i   (rd_en),
    .raddr_i(foff_m1[OW-1:0]),
    .rdata_o(hdr_rdata)
  );

  assign rsp_o = rsp_q;

endmodule

[rtl/core/aligned_stack_allocator_top.sv]
// aligned stack allocator: a request is captured on leaving idle and finished
// in exec, where the result and its strobe are registered; no new request is taken
// while busy, and a free needs the synchronous header ram read before top rewinds
// the receiver cannot stall: each result shows for exactly one cycle
// reset: top 0, arena_base 0, arena_size 4096; the header ram is not cleared
`timescale 1ns / 1ps

module aligned_stack_allocator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  asa_pkg::asa_req_t              req_i,
  // result channel
  output logic                           rsp_valid_o,
  output asa_pkg::asa_rsp_t              rsp_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [asa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [asa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  asa_pkg::asa_cmd_t cmd;

  // config writes are taken at any time; software keeps them to idle periods
  assign cfg_ready_o = 1'b1;

  // sequencer: idle takes a request, exec finishes it in the next cycle
  asa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .rsp_valid_o(rsp_valid_o),
    .cmd_o      (cmd)
  );

  // capture step: alignment and free-offset math, header read issued for a free
  // exec step: fit check, header write or top rewind, result registered
  asa_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp_o)
  );

  // a request accepted now is working in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // a result strobe follows each accept once the exec state ends
  a_accept_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 rsp_valid_o)
    else $error("result strobe missing after accepted request");

  // a result never shows while a request is still in flight
  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy)
    else $error("result strobe while busy");

  // failed requests return a zero address
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.ok) |-> (rsp_o.block_address == '0))
    else $error("failed request returned a nonzero address");

  // top never runs past the built store
  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.top_after <= asa_pkg::ARENA_LIMIT))
    else $error("top offset beyond arena");

endmodule
